@@ hdl/rm2h_pkg.sv @@
// Package: shared constants, sequencer states and heap ordering for the running median block
`timescale 1ns / 1ps
package rm2h_pkg;

   localparam int HALF_CAPACITY_DEF = 512;
   localparam int SAMPLE_W          = 32;

   // heap select codes
   localparam logic HEAP_LOWER = 1'b0;
   localparam logic HEAP_UPPER = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_CHECK,
      S_UP_CMP,
      S_DN_CHECK,
      S_DN_LEFT,
      S_DN_RIGHT,
      S_DN_CMP,
      S_FINISH,
      S_RESP
   } state_type;

   // true if a sits above b: max-heap for the lower half, min-heap for the upper half
   function automatic logic goes_before(input logic signed [SAMPLE_W-1:0] a,
                                        input logic signed [SAMPLE_W-1:0] b,
                                        input logic                       sel);
      goes_before = (sel == HEAP_LOWER) ? (a > b) : (a < b);
   endfunction

endpackage

@@ hdl/rm2h_heap.sv @@
// Heap storage: one write port and one read port with registered read data
`timescale 1ns / 1ps
module rm2h_heap
   import rm2h_pkg::*;
#(
   parameter int DEPTH = HALF_CAPACITY_DEF,
   parameter int AW    = $clog2(HALF_CAPACITY_DEF)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic signed [SAMPLE_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic signed [SAMPLE_W-1:0] rd_data
);

   logic signed [SAMPLE_W-1:0] mem [DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/rm2h_ctrl.sv @@
// Sequencer: placement decision, sift-up and sift-down over one heap at a time, result word
`timescale 1ns / 1ps
module rm2h_ctrl
   import rm2h_pkg::*;
#(
   parameter int HALF_CAPACITY = HALF_CAPACITY_DEF,
   parameter int AW            = $clog2(HALF_CAPACITY_DEF),
   parameter int CW            = $clog2(HALF_CAPACITY_DEF + 1),
   parameter int SCW           = $clog2(2 * HALF_CAPACITY_DEF + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [SAMPLE_W-1:0] sample,
   output logic                       rsp_valid,
   output logic signed [SAMPLE_W:0]   rsp_median,
   output logic [SCW-1:0]             rsp_count,
   output logic                       rsp_dropped,
   output logic                       lo_we,
   output logic                       hi_we,
   output logic [AW-1:0]              wr_addr,
   output logic signed [SAMPLE_W-1:0] wr_data,
   output logic                       lo_re,
   output logic                       hi_re,
   output logic [AW-1:0]              rd_addr,
   input  logic signed [SAMPLE_W-1:0] lo_rdata,
   input  logic signed [SAMPLE_W-1:0] hi_rdata
);

   localparam logic [CW-1:0] CAP = CW'(HALF_CAPACITY);

   state_type state_ff, state_in;

   logic [CW-1:0]              lo_cnt_ff, lo_cnt_in, hi_cnt_ff, hi_cnt_in;
   logic signed [SAMPLE_W-1:0] lo_root_ff, lo_root_in, hi_root_ff, hi_root_in;
   logic                       sel_ff, sel_in;
   logic signed [SAMPLE_W-1:0] val_ff, val_in;
   logic [AW-1:0]              idx_ff, idx_in;
   logic [AW-1:0]              par_ff, par_in;
   logic                       pend_ff, pend_in;
   logic signed [SAMPLE_W-1:0] pend_val_ff, pend_val_in;
   logic signed [SAMPLE_W-1:0] child_ff, child_in;
   logic [AW-1:0]              cidx_ff, cidx_in;
   logic                       drop_ff, drop_in;

   logic                       accept;
   logic signed [SAMPLE_W-1:0] rdata;
   logic [CW-1:0]              cur_cnt;
   logic [AW:0]                left_idx;
   logic [AW+1:0]              right_idx;
   logic [AW-1:0]              parent_idx;
   logic                       we;
   logic                       re;
   logic                       cmp_out;
   logic signed [SAMPLE_W-1:0] cmp_a, cmp_b;

   assign accept     = start && (state_ff == S_IDLE);
   assign rdata      = (sel_ff == HEAP_LOWER) ? lo_rdata : hi_rdata;
   assign cur_cnt    = (sel_ff == HEAP_LOWER) ? lo_cnt_ff : hi_cnt_ff;
   assign left_idx   = {idx_ff, 1'b1};
   assign right_idx  = {1'b0, left_idx} + (AW+2)'(1);
   assign parent_idx = (idx_ff - AW'(1)) >> 1;
   assign cmp_out    = goes_before(cmp_a, cmp_b, sel_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (start) state_in = S_UP_CHECK;
         S_UP_CHECK: state_in = (idx_ff == '0) ? S_FINISH : S_UP_CMP;
         S_UP_CMP:   state_in = cmp_out ? S_UP_CHECK : S_FINISH;
         S_DN_CHECK: state_in = ((AW+1)'(cur_cnt) <= left_idx) ? S_FINISH : S_DN_LEFT;
         S_DN_LEFT:  state_in = ((AW+2)'(cur_cnt) > right_idx) ? S_DN_RIGHT : S_DN_CMP;
         S_DN_RIGHT: state_in = S_DN_CMP;
         S_DN_CMP:   state_in = cmp_out ? S_DN_CHECK : S_FINISH;
         S_FINISH:   state_in = pend_ff ? S_UP_CHECK : S_RESP;
         S_RESP:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
      // the placement decision is taken at accept; drops and sift-downs skip ahead
      if (accept) begin
         if (drop_in) begin
            state_in = S_RESP;
         end else if (pend_in) begin
            state_in = S_DN_CHECK;
         end
      end
   end

   // datapath and outputs
   always_comb begin
      lo_cnt_in   = lo_cnt_ff;
      hi_cnt_in   = hi_cnt_ff;
      sel_in      = sel_ff;
      val_in      = val_ff;
      idx_in      = idx_ff;
      par_in      = par_ff;
      pend_in     = pend_ff;
      pend_val_in = pend_val_ff;
      child_in    = child_ff;
      cidx_in     = cidx_ff;
      drop_in     = drop_ff;
      we          = 1'b0;
      re          = 1'b0;
      wr_addr     = idx_ff;
      wr_data     = val_ff;
      rd_addr     = parent_idx;
      cmp_a       = val_ff;
      cmp_b       = rdata;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               drop_in     = 1'b0;
               pend_in     = 1'b0;
               val_in      = sample;
               pend_val_in = sample;
               if (lo_cnt_ff >= CAP && hi_cnt_ff >= CAP) begin
                  drop_in = 1'b1;
               end else if (lo_cnt_ff == '0) begin
                  sel_in    = HEAP_LOWER;
                  idx_in    = AW'(lo_cnt_ff);
                  lo_cnt_in = lo_cnt_ff + CW'(1);
               end else if (lo_cnt_ff == hi_cnt_ff) begin
                  if (sample < hi_root_ff) begin
                     sel_in    = HEAP_LOWER;
                     idx_in    = AW'(lo_cnt_ff);
                     lo_cnt_in = lo_cnt_ff + CW'(1);
                  end else begin
                     // upper root moves down, sample replaces it
                     sel_in      = HEAP_UPPER;
                     idx_in      = '0;
                     pend_in     = 1'b1;
                     pend_val_in = hi_root_ff;
                  end
               end else if ((hi_cnt_ff == '0 && sample > lo_root_ff) ||
                            (hi_cnt_ff != '0 && !(sample < lo_root_ff))) begin
                  sel_in    = HEAP_UPPER;
                  idx_in    = AW'(hi_cnt_ff);
                  hi_cnt_in = hi_cnt_ff + CW'(1);
               end else begin
                  // lower root moves up, sample replaces it
                  sel_in      = HEAP_LOWER;
                  idx_in      = '0;
                  pend_in     = 1'b1;
                  pend_val_in = lo_root_ff;
               end
            end
         end
         S_UP_CHECK: begin
            if (idx_ff == '0) begin
               we = 1'b1;
            end else begin
               re     = 1'b1;
               par_in = parent_idx;
            end
         end
         S_UP_CMP: begin
            we = 1'b1;
            if (cmp_out) begin
               wr_data = rdata;
               idx_in  = par_ff;
            end
         end
         S_DN_CHECK: begin
            rd_addr = AW'(left_idx);
            if ((AW+1)'(cur_cnt) <= left_idx) begin
               we = 1'b1;
            end else begin
               re = 1'b1;
            end
            cidx_in = AW'(left_idx);
         end
         S_DN_LEFT: begin
            child_in = rdata;
            rd_addr  = AW'(right_idx);
            if ((AW+2)'(cur_cnt) > right_idx) begin
               re = 1'b1;
            end
         end
         S_DN_RIGHT: begin
            // pick the right child when it sits above the left
            cmp_a = rdata;
            cmp_b = child_ff;
            if (cmp_out) begin
               child_in = rdata;
               cidx_in  = AW'(right_idx);
            end
         end
         S_DN_CMP: begin
            cmp_a = child_ff;
            cmp_b = val_ff;
            we    = 1'b1;
            if (cmp_out) begin
               wr_data = child_ff;
               idx_in  = cidx_ff;
            end
         end
         S_FINISH: begin
            if (pend_ff) begin
               pend_in = 1'b0;
               sel_in  = ~sel_ff;
               val_in  = pend_val_ff;
               if (sel_ff == HEAP_LOWER) begin
                  idx_in    = AW'(hi_cnt_ff);
                  hi_cnt_in = hi_cnt_ff + CW'(1);
               end else begin
                  idx_in    = AW'(lo_cnt_ff);
                  lo_cnt_in = lo_cnt_ff + CW'(1);
               end
            end
         end
         S_RESP: begin
         end
         default: begin
         end
      endcase
   end

   assign lo_we = we && (sel_ff == HEAP_LOWER);
   assign hi_we = we && (sel_ff == HEAP_UPPER);
   assign lo_re = re && (sel_ff == HEAP_LOWER);
   assign hi_re = re && (sel_ff == HEAP_UPPER);

   // track the roots so the decision needs no memory read
   always_comb begin
      lo_root_in = lo_root_ff;
      hi_root_in = hi_root_ff;
      if (lo_we && wr_addr == '0) lo_root_in = wr_data;
      if (hi_we && wr_addr == '0) hi_root_in = wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         lo_cnt_ff <= '0;
         hi_cnt_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         lo_cnt_ff <= lo_cnt_in;
         hi_cnt_ff <= hi_cnt_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_root_ff  <= lo_root_in;
      hi_root_ff  <= hi_root_in;
      sel_ff      <= sel_in;
      val_ff      <= val_in;
      idx_ff      <= idx_in;
      par_ff      <= par_in;
      pend_val_ff <= pend_val_in;
      child_ff    <= child_in;
      cidx_ff     <= cidx_in;
      drop_ff     <= drop_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = (state_ff == S_RESP);
   assign rsp_dropped = drop_ff;
   assign rsp_count   = SCW'(lo_cnt_ff) + SCW'(hi_cnt_ff);
   assign rsp_median  = (lo_cnt_ff > hi_cnt_ff) ?
                        ((SAMPLE_W+1)'(lo_root_ff) <<< 1) :
                        ((SAMPLE_W+1)'(lo_root_ff) + (SAMPLE_W+1)'(hi_root_ff));

endmodule

@@ hdl/running_median_two_heaps.sv @@
// Top level: two-heap running median of a signed 32-bit sample stream
`timescale 1ns / 1ps
// Pulse start while busy is low to hand in one sample. The block then sifts it
// through a max-heap (lower half) and a min-heap (upper half), one heap level at
// a time with one memory read per step, and raises rsp_valid for exactly one
// cycle with twice the median, the kept count and the drop flag. The receiver
// cannot stall: capture the result word in that cycle. Each heap memory has a
// single read port, so the sifting proceeds one read at a time, and no new
// sample is taken until the block is back in idle.
module running_median_two_heaps
   import rm2h_pkg::*;
#(
   parameter int HALF_CAPACITY = HALF_CAPACITY_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [SAMPLE_W-1:0]             req_sample,
   output logic                                   rsp_valid,
   output logic signed [SAMPLE_W:0]               rsp_median_times_two,
   output logic [$clog2(2*HALF_CAPACITY+1)-1:0]   rsp_sample_count,
   output logic                                   rsp_dropped
);

   localparam int AW  = $clog2(HALF_CAPACITY);
   localparam int CW  = $clog2(HALF_CAPACITY + 1);
   localparam int SCW = $clog2(2 * HALF_CAPACITY + 1);

   logic                       lo_we, hi_we, lo_re, hi_re;
   logic [AW-1:0]              wr_addr, rd_addr;
   logic signed [SAMPLE_W-1:0] wr_data, lo_rdata, hi_rdata;

   rm2h_ctrl #(
      .HALF_CAPACITY (HALF_CAPACITY),
      .AW            (AW),
      .CW            (CW),
      .SCW           (SCW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .sample      (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_median  (rsp_median_times_two),
      .rsp_count   (rsp_sample_count),
      .rsp_dropped (rsp_dropped),
      .lo_we       (lo_we),
      .hi_we       (hi_we),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .lo_re       (lo_re),
      .hi_re       (hi_re),
      .rd_addr     (rd_addr),
      .lo_rdata    (lo_rdata),
      .hi_rdata    (hi_rdata)
   );

   rm2h_heap #(.DEPTH(HALF_CAPACITY), .AW(AW)) u_lower (
      .clock   (clock),
      .wr_en   (lo_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (lo_re),
      .rd_addr (rd_addr),
      .rd_data (lo_rdata)
   );

   rm2h_heap #(.DEPTH(HALF_CAPACITY), .AW(AW)) u_upper (
      .clock   (clock),
      .wr_en   (hi_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (hi_re),
      .rd_addr (rd_addr),
      .rd_data (hi_rdata)
   );

endmodule
